// ===== rtl/core/vnd_pkg.sv =====
// ----------------------------------------------------------------------------
// vnd_pkg - shared definitions for the varint number decoder
// Operation codes, field widths and the result record passed between stages.
// ----------------------------------------------------------------------------
package vnd_pkg;

    // Field widths fixed by the stream format.
    localparam int BYTE_W  = 8;
    localparam int OP_W    = 2;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 4;

    // Default limit on the length of one varint, in bytes.
    localparam int MAX_VARINT_BYTES_DEF = 10;

    // Bits carried by one varint byte and the continuation flag position.
    localparam int GROUP_W  = 7;
    localparam int CONT_POS = 7;

    // Bytes in the fixed-width integers.
    localparam logic [COUNT_W-1:0] FIXED32_BYTES = 4'd4;
    localparam logic [COUNT_W-1:0] FIXED64_BYTES = 4'd8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_UVARINT = 2'd0;
    localparam logic [OP_W-1:0] OP_SVARINT = 2'd1;
    localparam logic [OP_W-1:0] OP_FIXED32 = 2'd2;
    localparam logic [OP_W-1:0] OP_FIXED64 = 2'd3;

    // One decoded number.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] bytes_used;
        logic               too_long;
    } t_result;

endpackage

// ===== rtl/core/vnd_step.sv =====
// ----------------------------------------------------------------------------
// vnd_step - per-byte decode step
// Holds the partial number and updates it with one byte per cycle while
// i_valid is high; flags a finished number together with its decoded result.
// ----------------------------------------------------------------------------
module vnd_step #(
    parameter int MAX_VARINT_BYTES = vnd_pkg::MAX_VARINT_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [vnd_pkg::BYTE_W-1:0]   i_byte,
    input  logic [vnd_pkg::OP_W-1:0]     i_op,
    output logic                         o_valid,
    output vnd_pkg::t_result             o_result
);
    import vnd_pkg::*;

    localparam logic [COUNT_W-1:0] MaxBytes = COUNT_W'(MAX_VARINT_BYTES);
    localparam int SHIFT_W = $clog2(VALUE_W);

    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [OP_W-1:0]    r_kind, n_kind;
    logic               r_in_num, n_in_num;

    logic [VALUE_W-1:0] cur_acc;
    logic [COUNT_W-1:0] cur_cnt;
    logic [OP_W-1:0]    cur_kind;
    logic [COUNT_W-1:0] count;
    logic [SHIFT_W-1:0] shift;
    logic [VALUE_W-1:0] group;
    logic [VALUE_W-1:0] half;
    logic               is_fixed;
    logic               cont;
    logic               done;
    t_result            res;

    always_comb begin
        // A new number starts from a cleared state and the current operation.
        cur_acc  = r_in_num ? r_acc  : '0;
        cur_cnt  = r_in_num ? r_cnt  : '0;
        cur_kind = r_in_num ? r_kind : i_op;

        is_fixed = (cur_kind == OP_FIXED32) || (cur_kind == OP_FIXED64);
        cont     = i_byte[CONT_POS];
        count    = cur_cnt + 1'b1;
        // Bit position of this group; at most nine groups precede it, so it fits.
        shift    = SHIFT_W'(cur_cnt) * SHIFT_W'(GROUP_W);
        group    = {{(VALUE_W-GROUP_W){1'b0}}, i_byte[GROUP_W-1:0]} << shift;
        half     = '0;

        res.value      = '0;
        res.bytes_used = count;
        res.too_long   = 1'b0;
        n_acc          = cur_acc;
        done           = 1'b0;

        if (is_fixed) begin
            // Big-endian: shift the byte in from the bottom.
            n_acc = {cur_acc[VALUE_W-BYTE_W-1:0], i_byte};
            if (cur_kind == OP_FIXED32) begin
                done      = (count >= FIXED32_BYTES);
                res.value = {{(VALUE_W-32){1'b0}}, n_acc[31:0]};
            end else begin
                done      = (count >= FIXED64_BYTES);
                res.value = n_acc;
            end
        end else begin
            // Little-endian 7-bit groups; groups past bit 63 are dropped.
            if (cur_cnt < 4'd10) begin
                n_acc = cur_acc | group;
            end
            done         = !cont || (count >= MaxBytes);
            res.too_long = cont;
            half         = n_acc >> 1;
            if (cur_kind == OP_SVARINT) begin
                res.value = n_acc[0] ? ~half : half;
            end else begin
                res.value = n_acc;
            end
        end

        // State update for an accepted byte.
        n_cnt    = r_cnt;
        n_kind   = r_kind;
        n_in_num = r_in_num;
        if (i_valid) begin
            n_kind = cur_kind;
            if (done) begin
                n_acc    = '0;
                n_cnt    = '0;
                n_in_num = 1'b0;
            end else begin
                n_cnt    = count;
                n_in_num = 1'b1;
            end
        end else begin
            n_acc = r_acc;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_cnt    <= '0;
            r_kind   <= OP_UVARINT;
            r_in_num <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_kind   <= n_kind;
            r_in_num <= n_in_num;
        end
    end

    assign o_valid  = i_valid && done;
    assign o_result = res;

endmodule

// ===== rtl/core/vnd_out_buf.sv =====
// ----------------------------------------------------------------------------
// vnd_out_buf - result register with skid stage
// Holds finished results for the output side so that a stall there does not
// stop the decode step until both entries are in use.
// ----------------------------------------------------------------------------
module vnd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vnd_pkg::t_result i_result,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output vnd_pkg::t_result o_result
);
    import vnd_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_valid && i_ready;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    assign o_space  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/core/varint_number_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// varint_number_decoder_unit - varint, zigzag and fixed-width integer decoder
// Decodes one stream byte per cycle into 64-bit numbers while the skid entry is free.
//
//  Channel   Dir  tdata (low bit up)                     tuser
//  s_axis    in   data_byte[7:0]                          operation[1:0]
//  m_axis    out  value[63:0], bytes_used[67:64], pad 0   too_long
//
//  One byte is accepted per cycle while the skid entry is free. The decode
//  step is combinational between the byte register and the result register,
//  so a byte is registered on entry and its number on the way out.
//  Reset (synchronous, active low) clears the partial number and all valids.
//  A stall on the output fills the result register and its skid entry; the
//  input stays ready until both are full.
// ----------------------------------------------------------------------------
module varint_number_decoder_unit #(
    parameter int MAX_VARINT_BYTES = vnd_pkg::MAX_VARINT_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // value[63:0], bytes_used[67:64], zeros
    output logic        m_axis_tuser    // too_long
);
    import vnd_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [OP_W-1:0]   r_in_op;
    logic              advance;
    logic              space;
    logic              step_valid;
    t_result           step_result;
    t_result           out_result;

    assign advance       = r_in_valid && space;
    assign s_axis_tready = !r_in_valid || advance;

    // Input byte register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_op   <= s_axis_tuser;
        end
    end

    // Decode step.
    vnd_step #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (advance),
        .i_byte   (r_in_byte),
        .i_op     (r_in_op),
        .o_valid  (step_valid),
        .o_result (step_result)
    );

    // Result register with skid entry.
    vnd_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (step_valid),
        .i_result (step_result),
        .o_space  (space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {4'b0000, out_result.bytes_used, out_result.value};
    assign m_axis_tuser = out_result.too_long;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - stream test of the varint number decoder
// Sends varint, zigzag and fixed-width numbers byte by byte, with random gaps
// on the input and random stalls on the output. A scoreboard decodes every
// accepted byte on its own and compares each decoded number, field by field,
// with the oldest number it expects.
// ----------------------------------------------------------------------------

// Decodes the byte stream alongside the block and checks its numbers.
class number_scoreboard;
    logic [63:0] partial;
    logic [3:0]  nbytes;
    logic [1:0]  kind;
    bit          busy;
    vnd_pkg::t_result expected_numbers[$];
    int unsigned errors;

    function new();
        partial = '0;
        nbytes  = '0;
        kind    = vnd_pkg::OP_UVARINT;
        busy    = 1'b0;
        errors  = 0;
    endfunction

    // Takes one accepted byte and queues a number when the byte ends one.
    function void note_byte(logic [7:0] b, logic [1:0] op);
        int unsigned count;
        int unsigned shift;
        int unsigned need;
        logic [63:0] v;
        vnd_pkg::t_result r;
        bit done;
        done = 1'b0;
        v = '0;
        r = '0;
        // The operation only counts on the first byte of a number.
        if (!busy) begin
            kind    = op;
            partial = '0;
            nbytes  = '0;
            busy    = 1'b1;
        end
        count = nbytes + 1;
        shift = vnd_pkg::GROUP_W * nbytes;
        nbytes = count[3:0];
        if (kind == vnd_pkg::OP_FIXED32 || kind == vnd_pkg::OP_FIXED64) begin
            // Big-endian: each byte shifts in from the bottom.
            need = (kind == vnd_pkg::OP_FIXED32) ? int'(vnd_pkg::FIXED32_BYTES)
                                                 : int'(vnd_pkg::FIXED64_BYTES);
            partial = {partial[55:0], b};
            if (count >= need) begin
                v = partial;
                if (kind == vnd_pkg::OP_FIXED32) begin
                    v[63:32] = '0;
                end
                r.too_long = 1'b0;
                done = 1'b1;
            end
        end else begin
            // Group bits that land at bit 64 or above are lost.
            if (shift < 64) begin
                partial = partial | ({57'd0, b[6:0]} << shift);
            end
            if (!b[vnd_pkg::CONT_POS] || count >= vnd_pkg::MAX_VARINT_BYTES_DEF) begin
                v = partial;
                if (kind == vnd_pkg::OP_SVARINT) begin
                    v = v[0] ? ~(v >> 1) : (v >> 1);
                end
                r.too_long = b[vnd_pkg::CONT_POS];
                done = 1'b1;
            end
        end
        if (done) begin
            r.value      = v;
            r.bytes_used = count[3:0];
            expected_numbers.push_back(r);
            partial = '0;
            nbytes  = '0;
            busy    = 1'b0;
        end
    endfunction

    // Compares one output item with the oldest expected number.
    function void check_number(logic [71:0] d, logic u);
        vnd_pkg::t_result want;
        if (expected_numbers.size() == 0) begin
            $error("unexpected number: value %h bytes_used %0d too_long %0b",
                   d[63:0], d[67:64], u);
            errors++;
        end else begin
            want = expected_numbers.pop_front();
            if (d[63:0] !== want.value) begin
                $error("value: expected %h, actual %h", want.value, d[63:0]);
                errors++;
            end
            if (d[67:64] !== want.bytes_used) begin
                $error("bytes_used: expected %0d, actual %0d", want.bytes_used, d[67:64]);
                errors++;
            end
            if (u !== want.too_long) begin
                $error("too_long: expected %0b, actual %0b", want.too_long, u);
                errors++;
            end
            if (d[71:68] !== 4'h0) begin
                $error("pad: expected 0, actual %h", d[71:68]);
                errors++;
            end
        end
    endfunction
endclass

module testbench;

    localparam int MAX_BYTES = vnd_pkg::MAX_VARINT_BYTES_DEF;
    localparam int ITEMS     = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;

    number_scoreboard sb;
    bit          calm = 1'b0;
    int unsigned sent_items = 0;
    int unsigned stall_left = 0;

    varint_number_decoder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then long, none while calm.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Output stalls of random length.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Both handshakes are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_number(m_axis_tdata, m_axis_tuser);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_byte(s_axis_tdata, s_axis_tuser);
            end
        end
    end

    // Offers one byte after a random gap and waits until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic [1:0] op);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    // Stops sending until every expected number has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_numbers.size() != 0) @(posedge i_clk);
    endtask

    // Encodes a value as a varint; later bytes carry a random operation.
    task automatic send_leb(input logic [63:0] v, input logic [1:0] op);
        logic [63:0] rest;
        logic [1:0]  o;
        rest = v;
        o = op;
        while (rest >= 64'd128) begin
            send_byte({1'b1, rest[6:0]}, o);
            rest = rest >> 7;
            o = 2'($urandom_range(0, 3));
        end
        send_byte({1'b0, rest[6:0]}, o);
    endtask

    // Random varint of a given length; the last byte may keep its flag set.
    task automatic send_groups(input int unsigned len, input bit cont_end,
                               input logic [1:0] op);
        logic [7:0] b;
        for (int unsigned i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            b[7] = (i + 1 < len) || cont_end;
            send_byte(b, (i == 0) ? op : 2'($urandom_range(0, 3)));
        end
    endtask

    // Random fixed-width integer.
    task automatic send_fixed(input logic [1:0] op);
        int unsigned n;
        n = (op == vnd_pkg::OP_FIXED32) ? int'(vnd_pkg::FIXED32_BYTES)
                                        : int'(vnd_pkg::FIXED64_BYTES);
        for (int unsigned i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(0, 255)), (i == 0) ? op : 2'($urandom_range(0, 3)));
        end
    endtask

    // Main sequence: reset, directed numbers, then random numbers.
    initial begin
        int unsigned r;
        logic [1:0]  vop;
        logic [63:0] v;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero as an unsigned number and minus one as a signed number.
        send_byte(8'h00, vnd_pkg::OP_UVARINT);
        send_byte(8'h01, vnd_pkg::OP_SVARINT);
        // All-ones 32-bit value, zero-extended; operation changes mid-number.
        send_byte(8'hFF, vnd_pkg::OP_FIXED32);
        send_byte(8'hFF, vnd_pkg::OP_UVARINT);
        send_byte(8'hFF, vnd_pkg::OP_SVARINT);
        send_byte(8'hFF, vnd_pkg::OP_FIXED64);
        // 64-bit value with the top and bottom bits set.
        send_byte(8'h80, vnd_pkg::OP_FIXED64);
        for (int i = 0; i < 6; i++) begin
            send_byte(8'h00, 2'(i));
        end
        send_byte(8'h01, vnd_pkg::OP_FIXED32);
        // Overlong signed varint: truncated, bits past 64 dropped, then zigzag.
        send_byte(8'hFF, vnd_pkg::OP_SVARINT);
        for (int i = 1; i < MAX_BYTES; i++) begin
            send_byte(8'hFF, 2'(i));
        end
        wait_drained();

        // Random numbers of every shape, plus stray bytes.
        while (sent_items < ITEMS) begin
            if ($urandom_range(0, 49) == 0) begin
                calm = !calm;
            end
            if ($urandom_range(0, 39) == 0) begin
                wait_drained();
            end
            vop = ($urandom_range(0, 1) != 0) ? vnd_pkg::OP_SVARINT : vnd_pkg::OP_UVARINT;
            r = $urandom_range(0, 99);
            if (r < 25) begin
                send_groups(($urandom_range(0, 3) != 0) ? $urandom_range(1, 3)
                                                        : $urandom_range(1, MAX_BYTES),
                            1'b0, vop);
            end else if (r < 35) begin
                case ($urandom_range(0, 3))
                    0: v = '1;
                    1: v = 64'h8000_0000_0000_0000;
                    2: v = '0;
                    default: v = {$urandom(), $urandom()} >> $urandom_range(0, 63);
                endcase
                send_leb(v, vop);
            end else if (r < 45) begin
                send_groups(MAX_BYTES, 1'b1, vop);
            end else if (r < 55) begin
                send_groups(MAX_BYTES, 1'b0, vop);
            end else if (r < 70) begin
                send_fixed(vnd_pkg::OP_FIXED32);
            end else if (r < 85) begin
                send_fixed(vnd_pkg::OP_FIXED64);
            end else begin
                send_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
            end
        end

        // Let the last numbers come out, then idle before the final check.
        calm = 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_numbers.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/vnd_pkg.sv
rtl/core/vnd_step.sv
rtl/core/vnd_out_buf.sv
rtl/core/varint_number_decoder_unit.sv
tb/testbench.sv
